FILE: hw/rtl/shb_pkg.sv
package shb_pkg;

    localparam int WORD_W     = 32;
    localparam int HASH_WORDS = 8;
    localparam int WIN_WORDS  = 16;
    localparam int ROUNDS     = 64;
    localparam int POS_W      = $clog2(WIN_WORDS);
    localparam int CNT_W      = $clog2(ROUNDS);
    localparam int OIDX_W     = $clog2(HASH_WORDS);

    typedef logic [WORD_W-1:0] word_t;

    // Working variables a..h sit at indices 0..7.
    typedef logic [HASH_WORDS-1:0][WORD_W-1:0] hash_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef struct packed {
        word_t message_word;
        logic  first_of_message;
        logic  last_of_message;
    } shb_in_t;

    typedef struct packed {
        word_t digest_word;
        logic  digest_last;
    } shb_out_t;

    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_idx;
        word_t            wr_data;
        logic             shift;
    } shb_sched_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } shb_round_ctl_t;

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t round_k(input logic [CNT_W-1:0] idx);
        word_t k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/shb_sched.sv
// Sixteen-word message window. Words are written by position while a block
// is collected; during compression the window shifts once per round and the
// new schedule word is expanded into the top.
module shb_sched
    import shb_pkg::*;
(
    input  logic           clk,
    input  shb_sched_ctl_t ctl,
    output word_t          w_head
);

    word_t win_reg [WIN_WORDS];
    word_t expand_next;

    always_comb
    begin
        expand_next = small_sigma1(win_reg[WIN_WORDS-2]) + win_reg[WIN_WORDS-7]
                    + small_sigma0(win_reg[1]) + win_reg[0];
    end

    assign w_head = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            for (int i = 0; i < WIN_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_WORDS-1] <= expand_next;
        end
        else if (ctl.wr_en)
        begin
            win_reg[ctl.wr_idx] <= ctl.wr_data;
        end
    end

endmodule

FILE: hw/rtl/shb_round.sv
// One SHA-256 round per step on the working variables a..h, with its own
// round counter that selects the round constant.
module shb_round
    import shb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  shb_round_ctl_t ctl,
    input  hash_t          chain,
    input  word_t          w_head,
    output hash_t          work,
    output logic           last_round
);

    hash_t            work_reg;
    hash_t            work_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    word_t            t1;
    word_t            t2;
    word_t            choose;
    word_t            major;

    always_comb
    begin
        choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
        t1 = work_reg[7] + big_sigma1(work_reg[4]) + choose + round_k(cnt_reg) + w_head;
        t2 = big_sigma0(work_reg[0]) + major;
        work_next    = work_reg;
        work_next[0] = t1 + t2;
        work_next[1] = work_reg[0];
        work_next[2] = work_reg[1];
        work_next[3] = work_reg[2];
        work_next[4] = work_reg[3] + t1;
        work_next[5] = work_reg[4];
        work_next[6] = work_reg[5];
        work_next[7] = work_reg[6];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.load)
        begin
            cnt_next = '0;
        end
        else if (ctl.step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            work_reg <= chain;
        end
        else if (ctl.step)
        begin
            work_reg <= work_next;
        end
    end

    assign work       = work_reg;
    assign last_round = (cnt_reg == CNT_W'(ROUNDS - 1));

endmodule

FILE: hw/rtl/sha256_block_hash.sv
// A word that does not complete a block is taken while idle; the sixteenth
// word of a block runs the single round unit through all its rounds, then
// the add state folds the result into the chain. After a word flagged last
// the eight digest words follow at one per cycle while out_ready is high.
// No word is taken during compression or output. Reset loads the initial
// hash, clears the word position and idles.
module sha256_block_hash
    import shb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  shb_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output shb_out_t out_data
);

    // The sequencer. Words are collected while idle; a full block runs the
    // round unit, the add state folds the result into the chain, and the
    // output state hands out the digest one word at a time.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos_eff;
    hash_t             chain_reg;
    hash_t             chain_next;
    logic              last_pend_reg;
    logic              last_pend_next;
    logic [OIDX_W-1:0] out_idx_reg;
    logic [OIDX_W-1:0] out_idx_next;
    logic              in_acc;
    shb_sched_ctl_t    sched_ctl;
    shb_round_ctl_t    round_ctl;
    word_t             w_head;
    hash_t             work;
    logic              rnd_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // A word flagged first always lands in slot 0 of a fresh block, whatever
    // partial block was being collected.
    assign pos_eff = in_data.first_of_message ? '0 : pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        chain_next     = chain_reg;
        last_pend_next = last_pend_reg;
        out_idx_next   = out_idx_reg;
        sched_ctl      = '0;
        round_ctl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    sched_ctl.wr_en   = 1'b1;
                    sched_ctl.wr_idx  = pos_eff;
                    sched_ctl.wr_data = in_data.message_word;
                    if (in_data.first_of_message)
                    begin
                        chain_next = INIT_HASH;
                    end
                    if (pos_eff == POS_W'(WIN_WORDS - 1))
                    begin
                        // The block is complete: the working variables take
                        // the chain now, and the window receives its last
                        // word at the same edge.
                        pos_next       = '0;
                        last_pend_next = in_data.last_of_message;
                        round_ctl.load = 1'b1;
                        state_next     = ST_ROUND;
                    end
                    else if (in_data.last_of_message)
                    begin
                        // A partial block is abandoned; the digest is that of
                        // the blocks already compressed.
                        pos_next     = '0;
                        out_idx_next = '0;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        pos_next = pos_eff + 1'b1;
                    end
                end
            end

            ST_ROUND:
            begin
                round_ctl.step  = 1'b1;
                sched_ctl.shift = 1'b1;
                if (rnd_last)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (last_pend_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == OIDX_W'(HASH_WORDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            chain_reg     <= INIT_HASH;
            last_pend_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            chain_reg     <= chain_next;
            last_pend_reg <= last_pend_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    // The digest is read straight from the chain registers, which do not
    // change while the output state holds.
    assign out_valid            = (state_reg == ST_OUT);
    assign out_data.digest_word = chain_reg[out_idx_reg];
    assign out_data.digest_last = (out_idx_reg == OIDX_W'(HASH_WORDS - 1));

    shb_sched u_sched (
        .clk    (clk),
        .ctl    (sched_ctl),
        .w_head (w_head)
    );

    shb_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (round_ctl),
        .chain      (chain_reg),
        .w_head     (w_head),
        .work       (work),
        .last_round (rnd_last)
    );

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (pos_eff == POS_W'(WIN_WORDS - 1)) |=> (state_reg == ST_ROUND))
        else $error("sixteenth word did not start compression");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && rnd_last |=> (state_reg == ST_ADD))
        else $error("compression did not end after the last round");

    a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.digest_last |=> in_ready)
        else $error("block not ready after the final digest word");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.last_of_message |=> (pos_reg == '0))
        else $error("word position not cleared after a last word");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import shb_pkg::*;

    // Scoreboard for the hash block. It keeps its own copy of the chaining
    // value, the sixteen-word schedule window and the slot position. It works
    // out the eight digest words that each accepted last-flagged word should
    // produce, and it checks every digest word that the block hands out.
    class digest_scoreboard;
        word_t      chain[8];
        word_t      window[16];
        logic [3:0] slot;
        word_t      iv[8];
        word_t      kk[64];
        shb_out_t   digest_q[$];
        int         errors;
        int         words_noted;
        int         blocks_done;
        int         digests_due;
        int         digest_words_checked;

        function new();
            iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
            kk = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                   32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                   32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                   32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                   32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                   32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                   32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                   32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                   32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                   32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                   32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                   32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                   32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                   32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                   32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                   32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            chain = iv;
            foreach (window[i])
            begin
                window[i] = '0;
            end
            slot = '0;
            errors = 0;
            words_noted = 0;
            blocks_done = 0;
            digests_due = 0;
            digest_words_checked = 0;
        endfunction

        function word_t rotr(word_t x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One 64-round compression of the current window into the chain.
        function void compress();
            word_t w[64];
            word_t s[8];
            word_t e, a, t1, t2, lo, hi;
            int r;
            for (r = 0; r < 16; r++)
            begin
                w[r] = window[r];
            end
            for (r = 16; r < 64; r++)
            begin
                lo = w[r-15];
                hi = w[r-2];
                w[r] = w[r-16] + (rotr(lo, 7) ^ rotr(lo, 18) ^ (lo >> 3)) + w[r-7]
                     + (rotr(hi, 17) ^ rotr(hi, 19) ^ (hi >> 10));
            end
            s = chain;
            for (r = 0; r < 64; r++)
            begin
                e = s[4];
                a = s[0];
                t1 = s[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
                   + ((e & s[5]) ^ (~e & s[6])) + kk[r] + w[r];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
                   + ((a & s[1]) ^ (a & s[2]) ^ (s[1] & s[2]));
                s[7] = s[6];
                s[6] = s[5];
                s[5] = s[4];
                s[4] = s[3] + t1;
                s[3] = s[2];
                s[2] = s[1];
                s[1] = s[0];
                s[0] = t1 + t2;
            end
            for (r = 0; r < 8; r++)
            begin
                chain[r] = chain[r] + s[r];
            end
            blocks_done++;
        endfunction

        function void note_word(shb_in_t item);
            shb_out_t d;
            words_noted++;
            if (item.first_of_message)
            begin
                chain = iv;
                slot = '0;
            end
            window[slot] = item.message_word;
            if (slot == 4'd15)
            begin
                compress();
                slot = '0;
            end
            else
            begin
                slot = slot + 4'd1;
            end
            if (item.last_of_message)
            begin
                slot = '0;
                digests_due++;
                for (int i = 0; i < 8; i++)
                begin
                    d.digest_word = chain[i];
                    d.digest_last = (i == 7);
                    digest_q.push_back(d);
                end
            end
        endfunction

        function void check_digest(shb_out_t got);
            shb_out_t want;
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h (last %b)", got.digest_word,
                       got.digest_last);
                errors++;
                return;
            end
            want = digest_q.pop_front();
            digest_words_checked++;
            if (got.digest_word !== want.digest_word)
            begin
                $error("digest_word: expected %h, got %h", want.digest_word,
                       got.digest_word);
                errors++;
            end
            if (got.digest_last !== want.digest_last)
            begin
                $error("digest_last: expected %b, got %b", want.digest_last,
                       got.digest_last);
                errors++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    // The run is stopped here if it has not finished by itself. The figure is
    // many times the slowest legal run: every word behind a full compression
    // and a long gap, every digest word behind a long stall.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 300;
    localparam int SETTLE_CYCLES = 100;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    shb_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    shb_out_t out_data;

    digest_scoreboard sb;

    int words_sent;
    int stall_left;
    int cycles;
    bit quiet;

    sha256_block_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog. A hang or a lost digest word ends up here.
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words still owed",
                     cycles, sb.pending());
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiving side. Outputs are sampled at the rising edge, before the
    // block's registers move, so the word seen is the one being handed over.
    // The ready line is then set for the next cycle, with random stalls until
    // the quiet part of the run.
    initial
    begin
        out_ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_digest(out_data);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Message words lean towards the extremes now and then, so that carries
    // and all-ones patterns turn up in the schedule and the rounds.
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, 31);
            3: return ~(word_t'(1) << $urandom_range(0, 31));
            default: return word_t'($urandom);
        endcase
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid stays
    // high afterwards, so back-to-back words need only one assignment per edge.
    task automatic send_word(word_t w, bit first, bit last);
        shb_in_t item;
        int gap;
        item.message_word     = w;
        item.first_of_message = first;
        item.last_of_message  = last;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_word(item);
        words_sent++;
    endtask

    // A run of words with the first flag on the opening word and the last
    // flag on the closing word, each only where asked.
    task automatic send_message(int n, bit with_first, bit with_last);
        for (int i = 0; i < n; i++)
        begin
            send_word(pick_word(), with_first && (i == 0), with_last && (i == n - 1));
        end
    endtask

    // Holds the sender back until every owed digest word has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    initial
    begin
        int target;
        int nblk;
        bit paused;
        sb = new();
        words_sent = 0;
        quiet = 1'b0;
        paused = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The padded one-block message for the text "abc", flagged first and
        // last, gives a well-known digest to start from.
        send_word(32'h61626380, 1'b1, 1'b0);
        for (int i = 1; i < 15; i++)
        begin
            send_word(32'h00000000, 1'b0, 1'b0);
        end
        send_word(32'h00000018, 1'b0, 1'b1);

        // Let the digest come out completely before going on.
        wait_drained();

        // Both flags on one word: the chain restarts, nothing is compressed,
        // and the digest is simply the initial hash.
        send_word(32'hffffffff, 1'b1, 1'b1);

        // No first flag after a last, and a last flag part-way through a
        // block: the partial block is dropped and the chain is reported as it
        // stood after the previous message.
        send_word(32'hffffffff, 1'b0, 1'b0);
        send_word(32'h00000000, 1'b0, 1'b1);

        // A first flag part-way through a block throws the partial block away
        // and starts afresh in slot 0.
        send_word(32'h80000000, 1'b0, 1'b0);
        send_word(32'h00000001, 1'b0, 1'b0);
        send_word(32'h7fffffff, 1'b1, 1'b0);
        send_word(32'hfffffffe, 1'b0, 1'b1);

        // Random part. Most of it is well-formed messages of one to three
        // blocks, some chaining on without a first flag; the rest is cut-off
        // blocks, restarts, lone words with both flags and plain noise.
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            if (words_sent > target - 50)
            begin
                quiet = 1'b1;
            end
            if (!paused && words_sent > target - 150)
            begin
                paused = 1'b1;
                wait_drained();
            end
            case ($urandom_range(0, 99)) inside
                [0:59]:
                begin
                    nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
                    send_message(16 * nblk, $urandom_range(0, 6) != 0, 1'b1);
                end
                [60:74]:
                begin
                    send_message(16 * $urandom_range(0, 1) + $urandom_range(1, 15),
                                 1'b1, 1'b1);
                end
                [75:84]:
                begin
                    send_message($urandom_range(1, 15), $urandom_range(0, 1), 1'b0);
                    send_message(16, 1'b1, 1'b1);
                end
                [85:89]:
                begin
                    send_word(pick_word(), 1'b1, 1'b1);
                end
                default:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        send_word(pick_word(), $urandom_range(0, 5) == 0,
                                  $urandom_range(0, 5) == 0);
                    end
                end
            endcase
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        // Room for a stray digest word or a compression still in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words, %0d blocks compressed, %0d digests owed, %0d digest words checked.",
                 sb.words_noted, sb.blocks_done, sb.digests_due, sb.digest_words_checked);
        $display("Covered chaining, truncated blocks, mid-block restarts and words with both flags.");
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
